FILE: hdl/mse_pkg.sv
// shared constants, instruction codes and the result record of the mips subset execute block
package mse_pkg;

   localparam int XLEN       = 32;
   localparam int REG_COUNT  = 32;
   localparam int RF_AW      = $clog2(REG_COUNT);
   localparam int DMEM_WORDS = 8192;
   localparam int DMEM_AW    = $clog2(DMEM_WORDS);
   localparam int PC_BITS    = 16;

   localparam logic [RF_AW-1:0] LINK_REG = RF_AW'(REG_COUNT - 1);

   // major opcodes
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_JAL   = 6'b000011;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_BNE   = 6'b000101;
   localparam logic [5:0] OP_ADDI  = 6'b001000;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;

   // r-type function codes
   localparam logic [5:0] FN_JR  = 6'b001000;
   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;
   localparam logic [5:0] FN_AND = 6'b100100;
   localparam logic [5:0] FN_OR  = 6'b100101;
   localparam logic [5:0] FN_SLT = 6'b101010;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL_OP = 2'd1;
   localparam logic [1:0] STATUS_BAD_FUNCT  = 2'd2;
   localparam logic [1:0] STATUS_END        = 2'd3;

   typedef struct packed {
      logic [PC_BITS-1:0] next_pc;
      logic               reg_written;
      logic [RF_AW-1:0]   reg_target;
      logic [XLEN-1:0]    reg_value;
      logic               mem_written;
      logic [DMEM_AW-1:0] mem_address;
      logic [XLEN-1:0]    mem_value;
      logic [1:0]         status;
   } result_type;

endpackage

FILE: hdl/mips_subset_execute.sv
// mips subset execute block: pc, register file and data memory with registered reads
//
// Usage: each transfer on the req_ channel carries one instruction word fetched at the
// pc that the previous result reported (zero after reset). Each instruction gives one
// transfer on the rsp_ channel: next pc, register write, store and status.
// csr_program_end sets the pc at which execution stops; write it only while idle.
// After reset the data memory is cleared one word per cycle, all DMEM_WORDS words
// (8192), with req_ready low; csr writes are taken during that time.
// A taken instruction is held in execute; its result goes to the output register once
// that is free. lw reads the data memory with the address formed from the register
// read and commits from a load state. Throughput: one instruction per cycle while the
// output register is free, not in the load state of lw; the register file read of the
// next instruction overlaps the current write back, bypassed on a matching register.
// The result sits in an output register; while the receiver stalls a finished result,
// one more instruction is taken and held in execute until the output register frees.
module mips_subset_execute (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_instruction,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mse_pkg::PC_BITS-1:0]    rsp_next_pc,
   output logic                           rsp_reg_written,
   output logic [mse_pkg::RF_AW-1:0]      rsp_reg_target,
   output logic signed [31:0]             rsp_reg_value,
   output logic                           rsp_mem_written,
   output logic [mse_pkg::DMEM_AW-1:0]    rsp_mem_address,
   output logic signed [31:0]             rsp_mem_value,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mse_pkg::PC_BITS-1:0]    csr_program_end
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;
   localparam logic [1:0] S_LOAD  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [mse_pkg::DMEM_AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [mse_pkg::PC_BITS-1:0]     pc_ff, pc_in;
   logic [mse_pkg::PC_BITS-1:0]     prog_end_ff, prog_end_in;
   logic [31:0]                     ins_ff, ins_in;
   logic [mse_pkg::REG_COUNT-1:0]   rf_valid_ff, rf_valid_in;
   logic                            zero_a_ff, zero_a_in, zero_b_ff, zero_b_in;
   logic                            fwd_a_ff, fwd_a_in, fwd_b_ff, fwd_b_in;
   logic [mse_pkg::XLEN-1:0]        fwd_data_ff, fwd_data_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mse_pkg::result_type             rsp_data_ff, rsp_data_in;

   logic [mse_pkg::XLEN-1:0]        rf_mem [mse_pkg::REG_COUNT];
   logic [mse_pkg::XLEN-1:0]        rf_rd_a_ff, rf_rd_b_ff;
   logic [mse_pkg::XLEN-1:0]        dmem_mem [mse_pkg::DMEM_WORDS];
   logic [mse_pkg::XLEN-1:0]        dmem_rd_ff;

   logic [5:0]                      op, fn;
   logic [mse_pkg::RF_AW-1:0]       rs, rt, rd, req_rs, req_rt;
   logic [mse_pkg::XLEN-1:0]        simm, a_val, b_val, addr_sum;
   logic [mse_pkg::PC_BITS-1:0]     pc1;
   logic                            at_end;
   logic                            wr_raw;
   logic [mse_pkg::RF_AW-1:0]       tgt_raw;
   logic [mse_pkg::XLEN-1:0]        val_raw;
   mse_pkg::result_type             res;
   logic                            load_go, out_free, commit, req_take;
   logic                            wb_en, dmem_we;
   logic [mse_pkg::RF_AW-1:0]       wb_addr;
   logic [mse_pkg::XLEN-1:0]        wb_data;

   // decode of the instruction in execute
   assign op     = ins_ff[31:26];
   assign rs     = ins_ff[25:21];
   assign rt     = ins_ff[20:16];
   assign rd     = ins_ff[15:11];
   assign fn     = ins_ff[5:0];
   assign simm   = {{(mse_pkg::XLEN - 16){ins_ff[15]}}, ins_ff[15:0]};
   assign req_rs = req_instruction[25:21];
   assign req_rt = req_instruction[20:16];

   // operand select: register 0 or never-written entry, bypass, or memory read
   assign a_val    = zero_a_ff ? '0 : (fwd_a_ff ? fwd_data_ff : rf_rd_a_ff);
   assign b_val    = zero_b_ff ? '0 : (fwd_b_ff ? fwd_data_ff : rf_rd_b_ff);
   assign addr_sum = a_val + simm;
   assign pc1      = pc_ff + 1'b1;
   assign at_end   = (pc_ff == prog_end_ff);

   always_comb begin
      res        = '0;
      res.next_pc = pc_ff;
      res.status = mse_pkg::STATUS_OK;
      wr_raw     = 1'b0;
      tgt_raw    = '0;
      val_raw    = '0;
      priority if (at_end) begin
         res.status = mse_pkg::STATUS_END;
      end else if (op == mse_pkg::OP_RTYPE) begin
         res.next_pc = pc1;
         wr_raw      = 1'b1;
         tgt_raw     = rd;
         unique case (fn)
            mse_pkg::FN_ADD: val_raw = a_val + b_val;
            mse_pkg::FN_SUB: val_raw = a_val - b_val;
            mse_pkg::FN_AND: val_raw = a_val & b_val;
            mse_pkg::FN_OR:  val_raw = a_val | b_val;
            mse_pkg::FN_SLT: val_raw = mse_pkg::XLEN'($signed(a_val) < $signed(b_val));
            mse_pkg::FN_JR: begin
               wr_raw      = 1'b0;
               res.next_pc = a_val[mse_pkg::PC_BITS-1:0];
            end
            default: begin
               wr_raw      = 1'b0;
               res.next_pc = pc_ff;
               res.status  = mse_pkg::STATUS_BAD_FUNCT;
            end
         endcase
      end else begin
         res.next_pc = pc1;
         unique case (op)
            mse_pkg::OP_ADDI: begin
               wr_raw  = 1'b1;
               tgt_raw = rt;
               val_raw = addr_sum;
            end
            mse_pkg::OP_BEQ: begin
               if (a_val == b_val) res.next_pc = pc1 + simm[mse_pkg::PC_BITS-1:0];
            end
            mse_pkg::OP_BNE: begin
               if (a_val != b_val) res.next_pc = pc1 + simm[mse_pkg::PC_BITS-1:0];
            end
            mse_pkg::OP_LW: begin
               // only committed from the load cycle, when the read data is in
               wr_raw  = 1'b1;
               tgt_raw = rt;
               val_raw = dmem_rd_ff;
            end
            mse_pkg::OP_SW: begin
               res.mem_written = 1'b1;
               res.mem_address = addr_sum[mse_pkg::DMEM_AW-1:0];
               res.mem_value   = b_val;
            end
            mse_pkg::OP_J: begin
               res.next_pc = ins_ff[mse_pkg::PC_BITS-1:0];
            end
            mse_pkg::OP_JAL: begin
               wr_raw      = 1'b1;
               tgt_raw     = mse_pkg::LINK_REG;
               val_raw     = mse_pkg::XLEN'(pc1);
               res.next_pc = ins_ff[mse_pkg::PC_BITS-1:0];
            end
            default: begin
               res.next_pc = pc_ff;
               res.status  = mse_pkg::STATUS_ILLEGAL_OP;
            end
         endcase
      end
      // writes to register 0 are dropped and reported as no write
      if (wr_raw && (tgt_raw != '0)) begin
         res.reg_written = 1'b1;
         res.reg_target  = tgt_raw;
         res.reg_value   = val_raw;
      end
   end

   assign load_go  = (state_ff == S_EXEC) && (op == mse_pkg::OP_LW) && !at_end;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = out_free && (((state_ff == S_EXEC) && !load_go) || (state_ff == S_LOAD));
   assign req_ready = (state_ff == S_IDLE) || commit;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign wb_en   = commit && res.reg_written;
   assign wb_addr = res.reg_target;
   assign wb_data = res.reg_value;
   assign dmem_we = commit && res.mem_written;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == mse_pkg::DMEM_AW'(mse_pkg::DMEM_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_take) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (load_go) state_in = S_LOAD;
            else if (commit) state_in = req_take ? S_EXEC : S_IDLE;
         end
         S_LOAD: begin
            if (commit) state_in = req_take ? S_EXEC : S_IDLE;
         end
      endcase
   end

   always_comb begin
      pc_in        = commit ? res.next_pc : pc_ff;
      prog_end_in  = csr_valid ? csr_program_end : prog_end_ff;
      rf_valid_in  = rf_valid_ff;
      if (wb_en) rf_valid_in[wb_addr] = 1'b1;
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = commit ? res : rsp_data_ff;
      ins_in       = ins_ff;
      fwd_a_in     = fwd_a_ff;
      fwd_b_in     = fwd_b_ff;
      zero_a_in    = zero_a_ff;
      zero_b_in    = zero_b_ff;
      fwd_data_in  = fwd_data_ff;
      if (req_take) begin
         // a write back at the same edge as the read is bypassed
         ins_in      = req_instruction;
         fwd_a_in    = wb_en && (wb_addr == req_rs);
         fwd_b_in    = wb_en && (wb_addr == req_rt);
         zero_a_in   = (req_rs == '0) || (!rf_valid_ff[req_rs] && !fwd_a_in);
         zero_b_in   = (req_rt == '0) || (!rf_valid_ff[req_rt] && !fwd_b_in);
         fwd_data_in = wb_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         pc_ff        <= '0;
         prog_end_ff  <= '1;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pc_ff        <= pc_in;
         prog_end_ff  <= prog_end_in;
         rf_valid_ff  <= rf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      fwd_a_ff    <= fwd_a_in;
      fwd_b_ff    <= fwd_b_in;
      zero_a_ff   <= zero_a_in;
      zero_b_ff   <= zero_b_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // register file, two read ports and one write port
   always_ff @(posedge clock) begin
      if (req_take) begin
         rf_rd_a_ff <= rf_mem[req_rs];
         rf_rd_b_ff <= rf_mem[req_rt];
      end
      if (wb_en) rf_mem[wb_addr] <= wb_data;
   end

   // data memory, cleared by the sweep after reset
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) dmem_mem[clr_addr_ff] <= '0;
      else if (dmem_we) dmem_mem[res.mem_address] <= res.mem_value;
      if (load_go) dmem_rd_ff <= dmem_mem[addr_sum[mse_pkg::DMEM_AW-1:0]];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_data_ff.next_pc;
   assign rsp_reg_written = rsp_data_ff.reg_written;
   assign rsp_reg_target  = rsp_data_ff.reg_target;
   assign rsp_reg_value   = $signed(rsp_data_ff.reg_value);
   assign rsp_mem_written = rsp_data_ff.mem_written;
   assign rsp_mem_address = rsp_data_ff.mem_address;
   assign rsp_mem_value   = $signed(rsp_data_ff.mem_value);
   assign rsp_status      = rsp_data_ff.status;

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> (wb_addr != '0))
      else $error("write back to register 0");

   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("instruction taken during memory clear");

   a_no_commit_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !commit)
      else $error("commit over a stalled result");

   a_fault_no_effect: assert property (@(posedge clock) disable iff (reset)
      (commit && (res.status != mse_pkg::STATUS_OK)) |->
         (!res.reg_written && !res.mem_written && (res.next_pc == pc_ff)))
      else $error("faulting or ended instruction changed state");

   a_load_follows_read: assert property (@(posedge clock) disable iff (reset)
      load_go |=> (state_ff == S_LOAD))
      else $error("load read not followed by load cycle");

endmodule

FILE: test/mse_checker.sv
// checker for the mips subset execute block: predicts each instruction and compares results
`timescale 1ns / 100ps

module mse_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [31:0]                    req_instruction,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [mse_pkg::PC_BITS-1:0]    rsp_next_pc,
   input  logic                           rsp_reg_written,
   input  logic [mse_pkg::RF_AW-1:0]      rsp_reg_target,
   input  logic signed [31:0]             rsp_reg_value,
   input  logic                           rsp_mem_written,
   input  logic [mse_pkg::DMEM_AW-1:0]    rsp_mem_address,
   input  logic signed [31:0]             rsp_mem_value,
   input  logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mse_pkg::PC_BITS-1:0]    csr_program_end,
   output logic                           idle,
   output int                             errors
);

   logic [mse_pkg::PC_BITS-1:0] cpu_pc;
   logic [mse_pkg::PC_BITS-1:0] stop_pc;
   logic [mse_pkg::XLEN-1:0]    gpr [mse_pkg::REG_COUNT];
   logic [mse_pkg::XLEN-1:0]    dmem [mse_pkg::DMEM_WORDS];
   mse_pkg::result_type         pending_results [$];

   // executes one instruction on the shadow state and builds its result record
   task automatic execute_instruction(input logic [31:0] ins,
                                      output mse_pkg::result_type res);
      logic [5:0]                  op;
      logic [5:0]                  fn;
      logic [4:0]                  rs;
      logic [4:0]                  rt;
      logic [4:0]                  rd;
      logic [mse_pkg::XLEN-1:0]    simm;
      logic [mse_pkg::XLEN-1:0]    a;
      logic [mse_pkg::XLEN-1:0]    b;
      logic [mse_pkg::XLEN-1:0]    eff;
      logic [mse_pkg::XLEN-1:0]    wv;
      logic [mse_pkg::PC_BITS-1:0] pc1;
      logic [mse_pkg::PC_BITS-1:0] npc;
      logic [4:0]                  wt;
      logic                        wr;
      op   = ins[31:26];
      rs   = ins[25:21];
      rt   = ins[20:16];
      rd   = ins[15:11];
      fn   = ins[5:0];
      simm = {{16{ins[15]}}, ins[15:0]};
      a    = gpr[rs];
      b    = gpr[rt];
      eff  = a + simm;
      pc1  = cpu_pc + 1'b1;
      npc  = cpu_pc;
      wr   = 1'b0;
      wt   = '0;
      wv   = '0;
      res  = '0;
      if (cpu_pc == stop_pc) begin
         res.status = mse_pkg::STATUS_END;
      end else if (op == mse_pkg::OP_RTYPE) begin
         npc = pc1;
         wr  = 1'b1;
         wt  = rd;
         case (fn)
            mse_pkg::FN_ADD: wv = a + b;
            mse_pkg::FN_SUB: wv = a - b;
            mse_pkg::FN_AND: wv = a & b;
            mse_pkg::FN_OR:  wv = a | b;
            mse_pkg::FN_SLT: wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            mse_pkg::FN_JR: begin
               wr  = 1'b0;
               npc = a[mse_pkg::PC_BITS-1:0];
            end
            default: begin
               wr         = 1'b0;
               npc        = cpu_pc;
               res.status = mse_pkg::STATUS_BAD_FUNCT;
            end
         endcase
      end else begin
         npc = pc1;
         case (op)
            mse_pkg::OP_ADDI: begin
               wr = 1'b1;
               wt = rt;
               wv = eff;
            end
            mse_pkg::OP_BEQ: if (a == b) npc = pc1 + simm[mse_pkg::PC_BITS-1:0];
            mse_pkg::OP_BNE: if (a != b) npc = pc1 + simm[mse_pkg::PC_BITS-1:0];
            mse_pkg::OP_LW: begin
               wr = 1'b1;
               wt = rt;
               wv = dmem[eff[mse_pkg::DMEM_AW-1:0]];
            end
            mse_pkg::OP_SW: begin
               res.mem_written = 1'b1;
               res.mem_address = eff[mse_pkg::DMEM_AW-1:0];
               res.mem_value   = b;
               dmem[eff[mse_pkg::DMEM_AW-1:0]] = b;
            end
            mse_pkg::OP_J: npc = ins[mse_pkg::PC_BITS-1:0];
            mse_pkg::OP_JAL: begin
               wr  = 1'b1;
               wt  = mse_pkg::LINK_REG;
               wv  = mse_pkg::XLEN'(pc1);
               npc = ins[mse_pkg::PC_BITS-1:0];
            end
            default: begin
               npc        = cpu_pc;
               res.status = mse_pkg::STATUS_ILLEGAL_OP;
            end
         endcase
      end
      // writes to register zero are dropped and not reported
      if (wr && wt != '0) begin
         gpr[wt]         = wv;
         res.reg_written = 1'b1;
         res.reg_target  = wt;
         res.reg_value   = wv;
      end
      cpu_pc      = npc;
      res.next_pc = npc;
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      mse_pkg::result_type want;
      if (reset) begin
         cpu_pc  = '0;
         stop_pc = '1;
         for (int i = 0; i < mse_pkg::REG_COUNT; i++) gpr[i] = '0;
         for (int i = 0; i < mse_pkg::DMEM_WORDS; i++) dmem[i] = '0;
         pending_results.delete();
         errors = 0;
         idle  <= 1'b1;
      end else begin
         // a result always belongs to an older instruction, so it is checked first
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result expected none, got next_pc %h status %0d",
                        $time, rsp_next_pc, rsp_status);
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("next_pc", 32'(want.next_pc), 32'(rsp_next_pc));
               check_field("reg_written", 32'(want.reg_written), 32'(rsp_reg_written));
               check_field("reg_target", 32'(want.reg_target), 32'(rsp_reg_target));
               check_field("reg_value", want.reg_value, rsp_reg_value);
               check_field("mem_written", 32'(want.mem_written), 32'(rsp_mem_written));
               check_field("mem_address", 32'(want.mem_address), 32'(rsp_mem_address));
               check_field("mem_value", want.mem_value, rsp_mem_value);
               check_field("status", 32'(want.status), 32'(rsp_status));
            end
         end
         if (csr_valid && csr_ready) stop_pc = csr_program_end;
         if (req_valid && req_ready) begin
            execute_instruction(req_instruction, want);
            pending_results.push_back(want);
         end
         idle <= (pending_results.size() == 0);
      end
   end

endmodule

FILE: test/tb.sv
// testbench top for the mips subset execute block: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_type;

   // codes outside the decoded set
   localparam logic [5:0] OP_UNUSED = 6'b111111;
   localparam logic [5:0] FN_UNUSED = 6'b000001;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [31:0]                         req_instruction = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [mse_pkg::PC_BITS-1:0]         rsp_next_pc;
   logic                                rsp_reg_written;
   logic [mse_pkg::RF_AW-1:0]           rsp_reg_target;
   logic signed [31:0]                  rsp_reg_value;
   logic                                rsp_mem_written;
   logic [mse_pkg::DMEM_AW-1:0]         rsp_mem_address;
   logic signed [31:0]                  rsp_mem_value;
   logic [1:0]                          rsp_status;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [mse_pkg::PC_BITS-1:0]         csr_program_end = '0;
   logic                                idle;
   int                                  errors;

   int                                  burst_left = 0;
   rx_mode_type                         rx_mode = RX_OPEN;
   int                                  rx_left = 0;

   mips_subset_execute u_dut (.*);
   mse_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[mips_subset_execute] ERROR");
      $finish;
   end

   // receiver stall pattern, switching to a randomly chosen mode at the end of each random run
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(32, 256);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= rx_left[3];
      endcase
   end

   function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd);
      return {mse_pkg::OP_RTYPE, rs, rt, rd, 5'($urandom()), fn};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   function automatic logic known_op(logic [5:0] op);
      case (op)
         mse_pkg::OP_RTYPE, mse_pkg::OP_J, mse_pkg::OP_JAL, mse_pkg::OP_BEQ,
         mse_pkg::OP_BNE, mse_pkg::OP_ADDI, mse_pkg::OP_LW, mse_pkg::OP_SW: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic known_funct(logic [5:0] fn);
      case (fn)
         mse_pkg::FN_JR, mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_AND,
         mse_pkg::FN_OR, mse_pkg::FN_SLT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // a few registers get most of the traffic so results feed later instructions
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, 7));
      return 5'($urandom());
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 16)) - 16'd8;
         1:       return 16'($urandom_range(0, 63));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [15:0] imm;
      rs  = pick_reg();
      rt  = pick_reg();
      rd  = pick_reg();
      imm = pick_imm();
      // loads and stores often go to a small window so loads find stored words
      if ($urandom_range(0, 1) == 0) begin
         op = mse_pkg::OP_LW;
      end
      case ($urandom_range(0, 19))
         0, 1: return $urandom();
         2: begin
            op = mse_pkg::OP_RTYPE;
            while (known_op(op)) op = 6'($urandom());
            return {op, 26'($urandom())};
         end
         3: begin
            fn = mse_pkg::FN_ADD;
            while (known_funct(fn)) fn = 6'($urandom());
            return {mse_pkg::OP_RTYPE, rs, rt, rd, 5'($urandom()), fn};
         end
         4, 5: return r_word(mse_pkg::FN_ADD, rs, rt, rd);
         6:    return r_word(mse_pkg::FN_SUB, rs, rt, rd);
         7:    return r_word(mse_pkg::FN_AND, rs, rt, rd);
         8:    return r_word(mse_pkg::FN_OR, rs, rt, rd);
         9:    return r_word(mse_pkg::FN_SLT, rs, rt, rd);
         10:   return r_word(mse_pkg::FN_JR, rs, rt, rd);
         11, 12: return i_word(mse_pkg::OP_ADDI, rs, rt, imm);
         13:   return i_word(mse_pkg::OP_BEQ, rs, rt, imm);
         14:   return i_word(mse_pkg::OP_BNE, rs, rt, imm);
         15, 16, 17: begin
            if ($urandom_range(0, 1) == 0) begin
               rs  = '0;
               imm = 16'($urandom_range(0, 63));
            end
            return i_word(($urandom_range(0, 2) == 0) ? mse_pkg::OP_SW : mse_pkg::OP_LW,
                          rs, rt, imm);
         end
         18:      return j_word(mse_pkg::OP_J, 26'($urandom()));
         default: return j_word(mse_pkg::OP_JAL, 26'($urandom()));
      endcase
   endfunction

   // one instruction transfer; bursts of random length with random gaps between them
   task automatic send_instruction(input logic [31:0] ins);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_instruction <= ins;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (!idle) @(posedge clock);
   endtask

   task automatic write_program_end(input logic [mse_pkg::PC_BITS-1:0] value);
      drain();
      csr_valid       <= 1'b1;
      csr_program_end <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // jump onto the stop address, then the pc stays there and reports end
   task automatic run_to_end(input logic [mse_pkg::PC_BITS-1:0] value);
      send_instruction(j_word(mse_pkg::OP_J, 26'(value)));
      send_instruction(random_instruction());
      send_instruction(random_instruction());
   endtask

   initial begin
      logic [mse_pkg::PC_BITS-1:0] stop_at;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_program_end(16'hFFFF);
      send_instruction(i_word(mse_pkg::OP_ADDI, 5'd0, 5'd1, 16'h7FFF));
      send_instruction(i_word(mse_pkg::OP_ADDI, 5'd0, 5'd2, 16'h8000));
      send_instruction(i_word(mse_pkg::OP_ADDI, 5'd0, 5'd3, 16'hFFFF));
      send_instruction(r_word(mse_pkg::FN_ADD, 5'd3, 5'd3, 5'd4));
      send_instruction(r_word(mse_pkg::FN_SUB, 5'd2, 5'd1, 5'd5));
      send_instruction(r_word(mse_pkg::FN_AND, 5'd3, 5'd1, 5'd6));
      send_instruction(r_word(mse_pkg::FN_OR, 5'd2, 5'd1, 5'd7));
      send_instruction(r_word(mse_pkg::FN_SLT, 5'd3, 5'd1, 5'd8));
      send_instruction(r_word(mse_pkg::FN_SLT, 5'd1, 5'd3, 5'd9));
      send_instruction(i_word(mse_pkg::OP_ADDI, 5'd1, 5'd0, 16'd5));
      send_instruction(r_word(mse_pkg::FN_ADD, 5'd1, 5'd1, 5'd0));
      send_instruction(i_word(mse_pkg::OP_SW, 5'd0, 5'd1, 16'hFFFF));
      send_instruction(i_word(mse_pkg::OP_LW, 5'd0, 5'd10, 16'h1FFF));
      send_instruction(i_word(mse_pkg::OP_SW, 5'd2, 5'd3, 16'h0000));
      send_instruction(i_word(mse_pkg::OP_LW, 5'd0, 5'd11, 16'h0000));
      send_instruction(i_word(mse_pkg::OP_BEQ, 5'd1, 5'd1, -16'd3));
      send_instruction(i_word(mse_pkg::OP_BEQ, 5'd1, 5'd2, 16'd5));
      send_instruction(i_word(mse_pkg::OP_BNE, 5'd1, 5'd2, 16'h7FFF));
      send_instruction(i_word(mse_pkg::OP_BNE, 5'd3, 5'd3, 16'd1));
      send_instruction(j_word(mse_pkg::OP_JAL, 26'h3FF_FFFF));
      send_instruction(r_word(mse_pkg::FN_JR, 5'd31, 5'd0, 5'd0));
      send_instruction(j_word(mse_pkg::OP_J, 26'h200_1234));
      send_instruction({OP_UNUSED, 26'h155_AAAA});
      send_instruction(r_word(FN_UNUSED, 5'd1, 5'd2, 5'd3));
      run_to_end(16'hFFFF);

      // pc sits at the top of the range: the next step wraps to zero and stops there
      write_program_end(16'h0000);
      send_instruction(i_word(mse_pkg::OP_ADDI, 5'd0, 5'd12, 16'h0001));
      send_instruction(random_instruction());
      send_instruction(random_instruction());

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            2:       stop_at = 16'hFFFF;
            4:       stop_at = 16'h0001;
            default: stop_at = 16'($urandom_range(2, 65534));
         endcase
         write_program_end(stop_at);
         repeat (280) send_instruction(random_instruction());
         run_to_end(stop_at);
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && idle) begin
         $display("[mips_subset_execute] OK");
      end else begin
         $display("[mips_subset_execute] ERROR");
      end
      $finish;
   end

endmodule
